// ----- rtl/core/tfpd_pkg.sv -----
package tfpd_pkg;

    localparam int RateW   = 20;
    localparam int AccelW  = 17;
    localparam int CfgW    = 16;
    localparam int CfgIdxW = 3;
    localparam int LimW    = 15;
    localparam int SpeedW  = 15;
    localparam int DerivW  = 32;
    localparam int BvW     = 16;

    // shared multiplier: 33 x 17 signed
    localparam int MulAW = 33;
    localparam int MulBW = 17;
    localparam int ProdW = MulAW + MulBW;

    // estimate difference (est - accel) * 2^16 + rate * T
    localparam int DiffW = 39;
    localparam int AccW  = 51;
    localparam int MixW  = 57;

    localparam logic signed [AccelW-1:0] TiltMax = 17'sd46080;
    localparam logic signed [AccelW-1:0] TiltMin = -17'sd46080;

    localparam logic [CfgIdxW-1:0] REG_GYRO_WEIGHT   = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_SAMPLE_PERIOD = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_DAMPING       = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_GAIN_P        = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_GAIN_D        = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_OUTPUT_LIMIT  = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_DEAD_BAND     = 3'd6;

    localparam logic [CfgW-1:0] RstGyroWeight   = 16'd64225;
    localparam logic [CfgW-1:0] RstSamplePeriod = 16'd655;
    localparam logic [CfgW-1:0] RstDamping      = 16'd55706;
    localparam logic [CfgW-1:0] RstGainP        = 16'd1536;
    localparam logic [CfgW-1:0] RstGainD        = 16'd2100;
    localparam logic [LimW-1:0] RstOutputLimit  = 15'd25600;
    localparam logic [LimW-1:0] RstDeadBand     = 15'd38;

    typedef struct packed {
        logic [CfgW-1:0] gyro_weight;
        logic [CfgW-1:0] sample_period;
        logic [CfgW-1:0] damping;
        logic [CfgW-1:0] gain_p;
        logic [CfgW-1:0] gain_d;
        logic [LimW-1:0] output_limit;
        logic [LimW-1:0] dead_band;
    } cfg_t;

    typedef enum logic [2:0] {
        MUL_RATE_T,
        MUL_DL_W,
        MUL_DH_W,
        MUL_ANG_KP,
        MUL_DA_DAMP,
        MUL_D_KD
    } mul_sel_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        logic     load_in;
        logic     load_diff;
        logic     load_acc;
        logic     load_angle;
        logic     load_da;
        logic     load_kp;
        logic     load_d;
        logic     load_bv;
        logic     load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic out_hold;
    } dp_status_t;

endpackage

// ----- rtl/core/tfpd_cfg.sv -----
module tfpd_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [tfpd_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [tfpd_pkg::CfgW-1:0]     cfg_data,
    output tfpd_pkg::cfg_t                cfg
);
    import tfpd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GYRO_WEIGHT:   cfg_next.gyro_weight   = cfg_data;
                REG_SAMPLE_PERIOD: cfg_next.sample_period = cfg_data;
                REG_DAMPING:       cfg_next.damping       = cfg_data;
                REG_GAIN_P:        cfg_next.gain_p        = cfg_data;
                REG_GAIN_D:        cfg_next.gain_d        = cfg_data;
                REG_OUTPUT_LIMIT:  cfg_next.output_limit  = cfg_data[LimW-1:0];
                REG_DEAD_BAND:     cfg_next.dead_band     = cfg_data[LimW-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gyro_weight   <= RstGyroWeight;
            cfg_reg.sample_period <= RstSamplePeriod;
            cfg_reg.damping       <= RstDamping;
            cfg_reg.gain_p        <= RstGainP;
            cfg_reg.gain_d        <= RstGainD;
            cfg_reg.output_limit  <= RstOutputLimit;
            cfg_reg.dead_band     <= RstDeadBand;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/core/tfpd_ctrl.sv -----
module tfpd_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  tfpd_pkg::dp_status_t  status,
    output tfpd_pkg::dp_cmd_t     cmd
);
    import tfpd_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_M1   = 4'd1;
    localparam logic [3:0] S_DIFF = 4'd2;
    localparam logic [3:0] S_M2   = 4'd3;
    localparam logic [3:0] S_M3   = 4'd4;
    localparam logic [3:0] S_MIX  = 4'd5;
    localparam logic [3:0] S_DSUM = 4'd6;
    localparam logic [3:0] S_M4   = 4'd7;
    localparam logic [3:0] S_DRND = 4'd8;
    localparam logic [3:0] S_M5   = 4'd9;
    localparam logic [3:0] S_BSUM = 4'd10;
    localparam logic [3:0] S_DEC  = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_sel = MUL_RATE_T;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load_in = in_valid;
                if (in_valid)
                begin
                    state_next = S_M1;
                end
            end
            S_M1:
            begin
                cmd.mul_sel = MUL_RATE_T;
                state_next  = S_DIFF;
            end
            S_DIFF:
            begin
                cmd.load_diff = 1'b1;
                state_next    = S_M2;
            end
            S_M2:
            begin
                cmd.mul_sel = MUL_DL_W;
                state_next  = S_M3;
            end
            S_M3:
            begin
                cmd.mul_sel  = MUL_DH_W;
                cmd.load_acc = 1'b1;
                state_next   = S_MIX;
            end
            S_MIX:
            begin
                cmd.load_angle = 1'b1;
                state_next     = S_DSUM;
            end
            S_DSUM:
            begin
                cmd.mul_sel = MUL_ANG_KP;
                cmd.load_da = 1'b1;
                state_next  = S_M4;
            end
            S_M4:
            begin
                cmd.mul_sel = MUL_DA_DAMP;
                cmd.load_kp = 1'b1;
                state_next  = S_DRND;
            end
            S_DRND:
            begin
                cmd.load_d = 1'b1;
                state_next = S_M5;
            end
            S_M5:
            begin
                cmd.mul_sel = MUL_D_KD;
                state_next  = S_BSUM;
            end
            S_BSUM:
            begin
                cmd.load_bv = 1'b1;
                state_next  = S_DEC;
            end
            S_DEC:
            begin
                // wait here while the previous result is still unclaimed
                if (!status.out_hold)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_M1))
        else $error("accepted beat did not start the sequence");

    a_dec_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DEC && status.out_hold) |=> (state_reg == S_DEC))
        else $error("left decision state while output held");

endmodule

// ----- rtl/core/tfpd_dp.sv -----
module tfpd_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  tfpd_pkg::cfg_t                     cfg,
    input  tfpd_pkg::dp_cmd_t                  cmd,
    output tfpd_pkg::dp_status_t               status,
    input  logic signed [tfpd_pkg::RateW-1:0]  tilt_rate,
    input  logic signed [tfpd_pkg::AccelW-1:0] accel_tilt,
    input  logic                               drive_enabled,
    input  logic                               out_stall,
    output logic                               out_valid,
    output logic [tfpd_pkg::SpeedW-1:0]        motor_speed,
    output logic                               motor_reverse,
    output logic                               motor_run,
    output logic signed [tfpd_pkg::AccelW-1:0] filtered_tilt
);
    import tfpd_pkg::*;

    localparam logic signed [DerivW-1:0] DMax = 32'sh7FFF_FFFF;
    localparam logic signed [DerivW-1:0] DMin = 32'sh8000_0000;

    logic signed [RateW-1:0]   rate_reg;
    logic signed [AccelW-1:0]  accel_reg;
    logic                      drive_reg;
    logic signed [ProdW-1:0]   prod_reg;
    logic signed [DiffW-1:0]   diff_reg;
    logic signed [AccW-1:0]    acc_reg;
    logic signed [AccelW-1:0]  est_reg;
    logic signed [MulAW-1:0]   da_reg;
    logic signed [AccelW+MulBW-1:0] kp_reg;
    logic signed [DerivW-1:0]  deriv_reg;
    logic signed [BvW-1:0]     bv_reg;

    logic                      out_valid_reg;
    logic [SpeedW-1:0]         speed_reg;
    logic                      rev_reg;
    logic                      run_reg;
    logic signed [AccelW-1:0]  tilt_out_reg;

    logic signed [MulAW-1:0]   mul_a;
    logic signed [MulBW-1:0]   mul_b;
    logic signed [ProdW-1:0]   prod_next;
    logic signed [DiffW-1:0]   diff_next;
    logic signed [AccW-1:0]    acc_next;
    logic signed [MixW-1:0]    mix;
    logic signed [MixW-33:0]   angle_raw;
    logic signed [AccelW-1:0]  est_next;
    logic signed [MulAW-1:0]   da_next;
    logic signed [ProdW-1:0]   d_rnd;
    logic signed [ProdW-17:0]  d_raw;
    logic signed [DerivW-1:0]  d_next;
    logic signed [ProdW-1:0]   bsum;
    logic signed [ProdW-9:0]   bv_raw;
    logic signed [BvW-1:0]     lim_s;
    logic signed [BvW-1:0]     db_s;
    logic signed [BvW-1:0]     bv_next;
    logic                      fwd;
    logic                      rev;
    logic                      corr;
    logic signed [BvW-1:0]     bv_adj;
    logic signed [BvW-1:0]     bv_fin;
    logic signed [BvW-1:0]     bv_neg;
    logic signed [DerivW-1:0]  d_adj;
    logic signed [DerivW-1:0]  d_quart;
    logic [SpeedW-1:0]         speed_next;

    // shared multiplier operand select
    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_RATE_T:
            begin
                mul_a = MulAW'(rate_reg);
                mul_b = MulBW'(cfg.sample_period);
            end
            MUL_DL_W:
            begin
                mul_a = MulAW'(diff_reg[15:0]);
                mul_b = MulBW'(cfg.gyro_weight);
            end
            MUL_DH_W:
            begin
                mul_a = MulAW'($signed(diff_reg[DiffW-1:16]));
                mul_b = MulBW'(cfg.gyro_weight);
            end
            MUL_ANG_KP:
            begin
                mul_a = MulAW'(est_reg);
                mul_b = MulBW'(cfg.gain_p);
            end
            MUL_DA_DAMP:
            begin
                mul_a = da_reg;
                mul_b = MulBW'(cfg.damping);
            end
            MUL_D_KD:
            begin
                mul_a = MulAW'(deriv_reg);
                mul_b = MulBW'(cfg.gain_d);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // (est - accel) * 2^16 + rate * T; mix = w * diff + accel * 2^32
    assign diff_next = DiffW'($signed({est_reg, 16'h0000}))
                     + $signed(prod_reg[DiffW-1:0])
                     - DiffW'($signed({accel_reg, 16'h0000}));

    // w * low half, accel term and rounding bias folded in ahead of the high half
    assign acc_next = AccW'($signed({accel_reg, 32'h0000_0000}))
                    + AccW'(prod_reg[31:0])
                    + AccW'(33'h0_8000_0000);

    assign mix       = $signed({prod_reg[MixW-17:0], 16'h0000}) + MixW'(acc_reg);
    assign angle_raw = $signed(mix[MixW-1:32]);

    always_comb
    begin
        priority if (angle_raw > TiltMax)
        begin
            est_next = TiltMax;
        end
        else if (angle_raw < TiltMin)
        begin
            est_next = TiltMin;
        end
        else
        begin
            est_next = angle_raw[AccelW-1:0];
        end
    end

    assign da_next = MulAW'(deriv_reg) + MulAW'(est_reg);

    assign d_rnd = prod_reg + ProdW'(32768);
    assign d_raw = $signed(d_rnd[ProdW-1:16]);

    always_comb
    begin
        priority if (d_raw > DMax)
        begin
            d_next = DMax;
        end
        else if (d_raw < DMin)
        begin
            d_next = DMin;
        end
        else
        begin
            d_next = d_raw[DerivW-1:0];
        end
    end

    assign bsum   = ProdW'(kp_reg) + prod_reg + ProdW'(128);
    assign bv_raw = $signed(bsum[ProdW-1:8]);
    assign lim_s  = $signed({1'b0, cfg.output_limit});
    assign db_s   = $signed({1'b0, cfg.dead_band});

    always_comb
    begin
        priority if (bv_raw > lim_s)
        begin
            bv_next = lim_s;
        end
        else if (bv_raw < -lim_s)
        begin
            bv_next = -lim_s;
        end
        else
        begin
            bv_next = bv_raw[BvW-1:0];
        end
    end

    // decision: dead band, direction and correction (divides truncate toward zero)
    assign fwd  = (bv_reg >= db_s);
    assign rev  = !fwd && (bv_reg <= -db_s) && drive_reg;
    assign corr = (fwd && (est_reg < 0) && drive_reg) || (rev && (est_reg > 0));

    assign bv_adj  = bv_reg + {{(BvW-1){1'b0}}, bv_reg[BvW-1]};
    assign bv_fin  = corr ? (bv_adj >>> 1) : bv_reg;
    assign bv_neg  = -bv_fin;
    assign d_adj   = deriv_reg + {{(DerivW-2){1'b0}}, {2{deriv_reg[DerivW-1]}}};
    assign d_quart = d_adj >>> 2;

    always_comb
    begin
        priority if (fwd)
        begin
            speed_next = bv_fin[SpeedW-1:0];
        end
        else if (rev)
        begin
            speed_next = bv_neg[SpeedW-1:0];
        end
        else
        begin
            speed_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (cmd.load_in)
        begin
            rate_reg  <= tilt_rate;
            accel_reg <= accel_tilt;
            drive_reg <= drive_enabled;
        end
        if (cmd.load_diff)
        begin
            diff_reg <= diff_next;
        end
        if (cmd.load_acc)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.load_da)
        begin
            da_reg <= da_next;
        end
        if (cmd.load_kp)
        begin
            kp_reg <= prod_reg[AccelW+MulBW-1:0];
        end
        if (cmd.load_bv)
        begin
            bv_reg <= bv_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            est_reg       <= '0;
            deriv_reg     <= '0;
            out_valid_reg <= 1'b0;
            speed_reg     <= '0;
            rev_reg       <= 1'b0;
            run_reg       <= 1'b0;
            tilt_out_reg  <= '0;
        end
        else
        begin
            if (cmd.load_angle)
            begin
                est_reg <= est_next;
            end
            if (cmd.load_d)
            begin
                deriv_reg <= d_next;
            end
            else if (cmd.load_out && corr)
            begin
                deriv_reg <= d_quart;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
                speed_reg     <= speed_next;
                rev_reg       <= rev;
                run_reg       <= fwd || rev;
                tilt_out_reg  <= est_reg;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.out_hold = out_valid_reg && out_stall;
    assign out_valid       = out_valid_reg;
    assign motor_speed     = speed_reg;
    assign motor_reverse   = rev_reg;
    assign motor_run       = run_reg;
    assign filtered_tilt   = tilt_out_reg;

    a_est_range: assert property (@(posedge clk) disable iff (!rst_n)
        (est_reg <= TiltMax) && (est_reg >= TiltMin))
        else $error("tilt estimate out of range");

    a_stop_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !run_reg |-> ((speed_reg == '0) && !rev_reg))
        else $error("stopped motors with speed or reverse set");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> !cmd.load_out)
        else $error("pending result overwritten");

endmodule

// ----- rtl/core/tilt_filter_pd_balance_controller_unit.sv -----
// A result beat is offered when the sequence for its accepted input beat ends.
// A new input beat is taken only after the previous one has gone through six
// products on the single shared 33x17 multiplier; the last step waits while the
// old result is unclaimed. A finished result sits in the output register while
// the next item is taken. Reset (rst_n low, asynchronous) restores register
// defaults and zeroes the tilt estimate and the derivative accumulator.
module tilt_filter_pd_balance_controller_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [tfpd_pkg::CfgIdxW-1:0]       cfg_index,
    input  logic [tfpd_pkg::CfgW-1:0]          cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [tfpd_pkg::RateW-1:0]  tilt_rate,
    input  logic signed [tfpd_pkg::AccelW-1:0] accel_tilt,
    input  logic                               drive_enabled,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [tfpd_pkg::SpeedW-1:0]        motor_speed,
    output logic                               motor_reverse,
    output logic                               motor_run,
    output logic signed [tfpd_pkg::AccelW-1:0] filtered_tilt
);
    import tfpd_pkg::*;

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    tfpd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tfpd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    tfpd_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .cmd           (cmd),
        .status        (status),
        .tilt_rate     (tilt_rate),
        .accel_tilt    (accel_tilt),
        .drive_enabled (drive_enabled),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .motor_speed   (motor_speed),
        .motor_reverse (motor_reverse),
        .motor_run     (motor_run),
        .filtered_tilt (filtered_tilt)
    );

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import tfpd_pkg::*;

    // index 7 decodes to no register
    localparam logic [CfgIdxW-1:0] RegSpare = 3'd7;
    localparam int QuietLimit  = 4000;
    localparam int DrainCycles = 16;
    localparam int RandomItems = 200;

    localparam logic signed [RateW-1:0] RateTop = {1'b0, {(RateW-1){1'b1}}};
    localparam logic signed [RateW-1:0] RateBot = {1'b1, {(RateW-1){1'b0}}};

    typedef struct packed {
        logic [SpeedW-1:0]        speed;
        logic                     reverse;
        logic                     run;
        logic signed [AccelW-1:0] tilt;
    } motor_cmd_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [CfgIdxW-1:0]       cfg_index = '0;
    logic [CfgW-1:0]          cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic signed [RateW-1:0]  tilt_rate = '0;
    logic signed [AccelW-1:0] accel_tilt = '0;
    logic                     drive_enabled = 1'b0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [SpeedW-1:0]        motor_speed;
    logic                     motor_reverse;
    logic                     motor_run;
    logic signed [AccelW-1:0] filtered_tilt;

    // mirror of the block's registers and loop state
    cfg_t       regs;
    longint     tilt_est;
    longint     deriv_acc;
    motor_cmd_t cmd_q[$];

    bit tx_gaps;
    bit rx_gaps;
    int errors;
    int items_sent;
    int cmds_seen;
    int settings_used;
    int quiet;

    tilt_filter_pd_balance_controller_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .tilt_rate     (tilt_rate),
        .accel_tilt    (accel_tilt),
        .drive_enabled (drive_enabled),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .motor_speed   (motor_speed),
        .motor_reverse (motor_reverse),
        .motor_run     (motor_run),
        .filtered_tilt (filtered_tilt)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // floor((v + half) / 2^s)
    function automatic longint round_shr(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint sat(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic motor_cmd_t balance_step(logic signed [RateW-1:0] rate,
                                                logic signed [AccelW-1:0] accel,
                                                logic drv);
        longint w, t, damp, kp, kd, lim, db, r, a, sum, mix, ang, d, bv;
        motor_cmd_t c;
        w    = regs.gyro_weight;
        t    = regs.sample_period;
        damp = regs.damping;
        kp   = regs.gain_p;
        kd   = regs.gain_d;
        lim  = regs.output_limit;
        db   = regs.dead_band;
        r    = rate;
        a    = accel;

        sum = tilt_est * 65536 + r * t;
        mix = w * sum + (65536 - w) * (a * 65536);
        ang = sat(round_shr(mix, 32), TiltMin, TiltMax);
        tilt_est = ang;

        d = round_shr((deriv_acc + ang) * damp, 16);
        d = sat(d, -64'sd2147483648, 64'sd2147483647);
        bv = sat(round_shr(ang * kp + d * kd, 8), -lim, lim);

        c = '0;
        if (bv >= db)
        begin
            // forward, correction only while drive is enabled
            if (ang < 0 && drv)
            begin
                d  = d / 4;
                bv = bv / 2;
            end
            c.speed = SpeedW'(bv);
            c.run   = 1'b1;
        end
        else if (bv <= -db && drv)
        begin
            if (ang > 0)
            begin
                d  = d / 4;
                bv = bv / 2;
            end
            c.speed   = SpeedW'(-bv);
            c.reverse = 1'b1;
            c.run     = 1'b1;
        end
        deriv_acc = d;
        c.tilt = AccelW'(ang);
        return c;
    endfunction

    function automatic int pick(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic cfg_t random_regs();
        cfg_t c;
        c.gyro_weight   = $urandom_range(1) ? 16'($urandom_range(65535, 60000))
                                            : 16'($urandom());
        c.sample_period = 16'($urandom());
        c.damping       = 16'($urandom());
        c.gain_p        = $urandom_range(1) ? 16'($urandom_range(4095)) : 16'($urandom());
        c.gain_d        = $urandom_range(1) ? 16'($urandom_range(4095)) : 16'($urandom());
        c.output_limit  = 15'($urandom_range(32767));
        c.dead_band     = $urandom_range(1) ? 15'($urandom_range(255))
                                            : 15'($urandom_range(32767));
        return c;
    endfunction

    task automatic check_field(string name, longint want, longint got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // leaves cfg_we high so back-to-back writes need no toggle
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_GYRO_WEIGHT:   regs.gyro_weight   = data;
            REG_SAMPLE_PERIOD: regs.sample_period = data;
            REG_DAMPING:       regs.damping       = data;
            REG_GAIN_P:        regs.gain_p        = data;
            REG_GAIN_D:        regs.gain_d        = data;
            REG_OUTPUT_LIMIT:  regs.output_limit  = data[LimW-1:0];
            REG_DEAD_BAND:     regs.dead_band     = data[LimW-1:0];
            default: ;
        endcase
    endtask

    task automatic load_regs(input cfg_t c);
        write_reg(REG_GYRO_WEIGHT, c.gyro_weight);
        write_reg(REG_SAMPLE_PERIOD, c.sample_period);
        write_reg(REG_DAMPING, c.damping);
        write_reg(REG_GAIN_P, c.gain_p);
        write_reg(REG_GAIN_D, c.gain_d);
        // spare top bit must be dropped by the 15-bit registers
        write_reg(REG_OUTPUT_LIMIT, {1'($urandom_range(1)), c.output_limit});
        write_reg(REG_DEAD_BAND, {1'($urandom_range(1)), c.dead_band});
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic drain_wait();
        in_valid <= 1'b0;
        while (cmd_q.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic send_tilt(input logic signed [RateW-1:0] r,
                             input logic signed [AccelW-1:0] a,
                             input logic de);
        if (tx_gaps)
            while ($urandom_range(99) < 33)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        in_valid      <= 1'b1;
        tilt_rate     <= r;
        accel_tilt    <= a;
        drive_enabled <= de;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        cmd_q.push_back(balance_step(r, a, de));
        items_sent++;
    endtask

    task automatic send_random();
        int mode;
        logic signed [RateW-1:0]  r;
        logic signed [AccelW-1:0] a;
        mode = $urandom_range(9);
        if (mode < 2)
        begin
            r = RateW'($urandom());
            a = AccelW'(pick(-46080, 46080));
        end
        else if (mode < 6)
        begin
            r = RateW'(pick(-1024, 1024));
            a = AccelW'(pick(-512, 512));
        end
        else if (mode < 9)
        begin
            r = RateW'(pick(-65536, 65536));
            a = AccelW'(pick(-8192, 8192));
        end
        else
        begin
            case ($urandom_range(2))
                0: r = RateTop;
                1: r = RateBot;
                default: r = '0;
            endcase
            case ($urandom_range(2))
                0: a = TiltMax;
                1: a = TiltMin;
                default: a = '0;
            endcase
        end
        send_tilt(r, a, $urandom_range(3) != 0);
    endtask

    task automatic test_directed_corners();
        send_tilt('0, '0, 1'b1);
        send_tilt(RateTop, TiltMax, 1'b1);
        send_tilt(RateTop, TiltMax, 1'b0);
        send_tilt(RateBot, TiltMin, 1'b1);
        send_tilt(RateBot, TiltMin, 1'b0);
        send_tilt('0, TiltMin, 1'b1);
        send_tilt('0, TiltMax, 1'b1);
        send_tilt(RateBot, TiltMax, 1'b1);
        send_tilt(RateTop, TiltMin, 1'b0);
    endtask

    task automatic test_zero_dead_band();
        cfg_t c;
        // zero gyro weight: the estimate follows the accelerometer directly
        c = regs;
        c.gyro_weight = '0;
        c.damping     = '0;
        c.dead_band   = '0;
        drain_wait();
        load_regs(c);
        send_tilt(RateTop, '0, 1'b1);
        send_tilt('0, '0, 1'b0);
        send_tilt('0, -17'sd1, 1'b1);
        c.output_limit = '0;
        drain_wait();
        load_regs(c);
        send_tilt('0, TiltMax, 1'b1);
        send_tilt('0, TiltMin, 1'b1);
    endtask

    task automatic test_correction_paths();
        cfg_t c;
        c.gyro_weight   = '0;
        c.sample_period = RstSamplePeriod;
        c.damping       = 16'hFFFF;
        c.gain_p        = 16'd256;
        c.gain_d        = 16'd256;
        c.output_limit  = 15'h7FFF;
        c.dead_band     = 15'd1;
        drain_wait();
        load_regs(c);
        // build a positive accumulator, then flip the angle; then the same with signs swapped
        send_tilt('0, 17'sd20000, 1'b1);
        send_tilt('0, 17'sd20000, 1'b1);
        send_tilt('0, -17'sd10000, 1'b1);
        send_tilt('0, 17'sd20000, 1'b1);
        send_tilt('0, 17'sd20000, 1'b1);
        send_tilt('0, -17'sd10000, 1'b0);
        send_tilt('0, -17'sd20000, 1'b1);
        send_tilt('0, -17'sd20000, 1'b1);
        send_tilt('0, 17'sd10000, 1'b1);
        send_tilt('0, -17'sd20000, 1'b1);
        send_tilt('0, 17'sd10000, 1'b0);
    endtask

    task automatic test_spare_index();
        drain_wait();
        write_reg(RegSpare, CfgW'($urandom()));
        cfg_we <= 1'b0;
        repeat (5) send_random();
    endtask

    task automatic test_random_settings();
        cfg_t c;
        for (int k = 0; k < 7; k++)
        begin
            case (k)
                0: c = {RstGyroWeight, RstSamplePeriod, RstDamping, RstGainP, RstGainD,
                        RstOutputLimit, RstDeadBand};
                1: c = '1;
                2: c = '0;
                3:
                begin
                    c = random_regs();
                    c.output_limit = LimW'($urandom_range(2000));
                    c.dead_band    = LimW'(c.output_limit + 1 + $urandom_range(1000));
                end
                default: c = random_regs();
            endcase
            drain_wait();
            load_regs(c);
            repeat (RandomItems) send_random();
        end
    endtask

    task automatic test_gap_free_burst();
        drain_wait();
        load_regs(random_regs());
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        repeat (300) send_random();
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
    endtask

    // result side: compare each accepted beat, then choose next stall
    always @(posedge clk)
    begin : result_check
        motor_cmd_t want;
        if (out_valid && !out_stall)
        begin
            cmds_seen++;
            if (cmd_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result beat, speed %0d run %0d", $time,
                         motor_speed, motor_run);
            end
            else
            begin
                want = cmd_q.pop_front();
                check_field("motor_speed", want.speed, motor_speed);
                check_field("motor_reverse", want.reverse, motor_reverse);
                check_field("motor_run", want.run, motor_run);
                check_field("filtered_tilt", want.tilt, filtered_tilt);
            end
        end
        out_stall <= rx_gaps && ($urandom_range(99) < 33);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QuietLimit)
        begin
            $display("%0t: no beat accepted for %0d cycles", $time, QuietLimit);
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        errors        = 0;
        items_sent    = 0;
        cmds_seen     = 0;
        settings_used = 0;
        quiet         = 0;
        tilt_est      = 0;
        deriv_acc     = 0;
        regs = {RstGyroWeight, RstSamplePeriod, RstDamping, RstGainP, RstGainD,
                RstOutputLimit, RstDeadBand};
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_corners();
        test_zero_dead_band();
        test_correction_paths();
        test_spare_index();
        test_random_settings();
        test_gap_free_burst();
        drain_wait();

        $display("Drove %0d tilt samples over %0d register settings, %0d results checked.",
                 items_sent, settings_used, cmds_seen);
        $display("Covered corners, zero dead band, correction paths and random sweeps.");
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/tfpd_pkg.sv
rtl/core/tfpd_cfg.sv
rtl/core/tfpd_ctrl.sv
rtl/core/tfpd_dp.sv
rtl/core/tilt_filter_pd_balance_controller_unit.sv
verif/tb.sv
